>>> sv/lpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared types and constants for the LFO phase-modulation effect: widths of
// the serial multiplier, fixed-point constants and the cosine table builder.
// ----------------------------------------------------------------------------
package lpm_pkg;

	// cosine samples, signed Q1.15; table magnitudes unsigned 15 bits
	localparam int COS_W  = 16;
	localparam int QCOS_W = 15;

	// radian argument, Q.23, wide enough for x and depth*cos
	localparam int ARG_W  = 34;

	// 1/(2*pi) in Q32, and its width as a multiplier operand
	localparam int INV_W = 30;
	localparam logic [INV_W-1:0] INV_TWO_PI_Q32 = 30'd683565276;

	// serial multiplier: multiplicand, multiplier and product widths
	localparam int MUL_AW = ARG_W;
	localparam int MUL_BW = INV_W;
	localparam int MUL_PW = 55;
	localparam int MUL_CW = 5;

	// configuration port
	localparam int CFG_AW = 3;
	localparam logic [15:0] DEPTH_RESET = 16'd2560;

	typedef enum logic {
		REG_PHASE_INC = 1'b0,
		REG_MOD_DEPTH = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic              start;
		logic              msb_neg;  // top multiplier bit carries negative weight
		logic [MUL_CW-1:0] nbits;
	} mul_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_sts_t;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

	// Quarter-wave cosine entry k, 2^qbits steps over [0, pi/2].
	// Eight-term Taylor series in Q30, used at elaboration only.
	function automatic logic [QCOS_W-1:0] cos_entry(input int unsigned k,
		input int unsigned qbits);
		logic        [63:0] x;
		logic        [63:0] x2;
		logic        [63:0] t;
		logic signed [63:0] s;
		logic        [63:0] q;
		x  = (64'(k) * HALF_PI_Q30) >> qbits;
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		s  = $signed(ONE_Q30);
		t  = ((t * x2) >> 30) / 64'd2;
		s  = s - $signed(t);
		t  = ((t * x2) >> 30) / 64'd12;
		s  = s + $signed(t);
		t  = ((t * x2) >> 30) / 64'd30;
		s  = s - $signed(t);
		t  = ((t * x2) >> 30) / 64'd56;
		s  = s + $signed(t);
		t  = ((t * x2) >> 30) / 64'd90;
		s  = s - $signed(t);
		t  = ((t * x2) >> 30) / 64'd132;
		s  = s + $signed(t);
		t  = ((t * x2) >> 30) / 64'd182;
		s  = s - $signed(t);
		if (s < 0) begin
			s = 64'sd0;
		end
		q = (64'(s) + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return q[QCOS_W-1:0];
	endfunction

endpackage

>>> sv/lpm_coslut.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_coslut
// Full-turn cosine lookup from a quarter-wave table, registered output.
// Top two index bits pick the quadrant; the rest mirror and negate.
// ----------------------------------------------------------------------------
module lpm_coslut import lpm_pkg::*; #(
	parameter int ADDR_BITS = 10
) (
	input  logic                        clk,
	input  logic [ADDR_BITS-1:0]        idx,
	output logic signed [COS_W-1:0]     cos_val
);

	localparam int QBITS = ADDR_BITS - 2;
	localparam int QLEN  = 2 ** QBITS;
	localparam logic [QBITS:0] QLEN_V = (QBITS + 1)'(QLEN);

	logic [QCOS_W-1:0] qcos [QLEN+1];

	for (genvar k = 0; k <= QLEN; k++) begin : g_qcos
		assign qcos[k] = cos_entry(k, QBITS);
	end

	logic [1:0]       quad;
	logic [QBITS-1:0] r;
	logic [QBITS:0]   addr;
	logic             neg;
	logic [QCOS_W-1:0] mag;

	always_comb begin
		quad = idx[ADDR_BITS-1 -: 2];
		r    = idx[QBITS-1:0];
		case (quad)
			2'd0: begin
				addr = {1'b0, r};
				neg  = 1'b0;
			end
			2'd1: begin
				addr = QLEN_V - {1'b0, r};
				neg  = 1'b1;
			end
			2'd2: begin
				addr = {1'b0, r};
				neg  = 1'b1;
			end
			default: begin
				addr = QLEN_V - {1'b0, r};
				neg  = 1'b0;
			end
		endcase
		mag = qcos[addr];
	end

	always_ff @(posedge clk) begin
		if (neg) begin
			cos_val <= -$signed({1'b0, mag});
		end else begin
			cos_val <= $signed({1'b0, mag});
		end
	end

endmodule

>>> sv/lpm_sermul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_sermul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// Product is kept modulo 2^MUL_PW; the top bit may carry negative weight.
// ----------------------------------------------------------------------------
module lpm_sermul import lpm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mul_ctl_t                  ctl,
	input  logic signed [MUL_AW-1:0]  mcand,
	input  logic [MUL_BW-1:0]         mplier,
	output mul_sts_t                  sts,
	output logic [MUL_PW-1:0]         prod
);

	logic [MUL_PW-1:0] mcand_q;
	logic [MUL_BW-1:0] mplier_q;
	logic [MUL_PW-1:0] acc_q;
	logic [MUL_CW-1:0] cnt_q;
	logic              neg_q;
	logic              busy_q;
	logic              done_q;
	logic              last;

	assign last = (cnt_q == MUL_CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !ctl.start && busy_q && last;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - MUL_CW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mcand_q  <= MUL_PW'(mcand);
			mplier_q <= mplier;
			acc_q    <= '0;
			neg_q    <= ctl.msb_neg;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				if (last && neg_q) begin
					acc_q <= acc_q - mcand_q;
				end else begin
					acc_q <= acc_q + mcand_q;
				end
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign prod     = acc_q;

endmodule

>>> sv/lfo_phase_modulation_effect.sv
`timescale 1ns / 1ps
// Each item runs three passes of the one bit-serial multiplier, over 16, 30
// and SAMPLE_BITS multiplier bits, plus two cosine table reads; a new item is
// taken only after the last result has been loaded into the output register.
// Reset (arst_n low): oscillator phase and phase_increment clear to 0,
// mod_depth loads 10.0 rad, no item in flight, no result pending.
// ----------------------------------------------------------------------------
// lfo_phase_modulation_effect
// Per-sample effect y = x * cos(x + depth * cos(lfo_phase)), Q1.15 audio,
// built around a shared bit-serial multiplier and one cosine table.
// ----------------------------------------------------------------------------
module lfo_phase_modulation_effect import lpm_pkg::*; #(
	parameter int PHASE_BITS    = 32,
	parameter int COS_ADDR_BITS = 10,
	parameter int SAMPLE_BITS   = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// sample input
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [SAMPLE_BITS-1:0]  sample_in,
	// sample output
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [SAMPLE_BITS-1:0]  sample_out,
	// configuration
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [CFG_AW-1:0]       paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int XSH   = 24 - SAMPLE_BITS;
	localparam int P3_W  = SAMPLE_BITS + 16;
	localparam int SUM_W = SAMPLE_BITS + 17;
	localparam int YW    = SAMPLE_BITS + 2;
	localparam logic signed [YW-1:0] YMAX = YW'(2 ** (SAMPLE_BITS - 1) - 1);
	localparam logic signed [YW-1:0] YMIN = ~YMAX;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LFO,
		ST_M1,
		ST_W1,
		ST_M2,
		ST_W2,
		ST_LUT2,
		ST_M3,
		ST_W3,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [31:0]              inc_q;
	logic [15:0]              depth_q;
	logic [PHASE_BITS-1:0]    phase_q;
	logic [SAMPLE_BITS-1:0]   x_q;
	logic signed [ARG_W-1:0]  arg_q;
	logic                     out_valid_q;
	logic [SAMPLE_BITS-1:0]   sample_out_q;

	// ---------------- configuration port ----------------
	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q   <= '0;
			depth_q <= DEPTH_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_PHASE_INC: inc_q   <= pwdata;
				REG_MOD_DEPTH: depth_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_PHASE_INC: prdata = inc_q;
			REG_MOD_DEPTH: prdata = {16'd0, depth_q};
			default:       prdata = '0;
		endcase
	end

	// ---------------- shared datapath units ----------------
	logic [COS_ADDR_BITS-1:0]  lut_idx;
	logic signed [COS_W-1:0]   lut_cos;
	mul_ctl_t                  mul_ctl;
	mul_sts_t                  mul_sts;
	logic signed [MUL_AW-1:0]  mul_a;
	logic [MUL_BW-1:0]         mul_b;
	logic [MUL_PW-1:0]         mul_p;

	// oscillator phase first, then the turn count of the full argument
	assign lut_idx = (state_q == ST_LFO) ? phase_q[PHASE_BITS-1 -: COS_ADDR_BITS]
	                                     : mul_p[MUL_PW-1 -: COS_ADDR_BITS];

	lpm_coslut #(
		.ADDR_BITS (COS_ADDR_BITS)
	) u_coslut (
		.clk     (clk),
		.idx     (lut_idx),
		.cos_val (lut_cos)
	);

	always_comb begin
		mul_ctl.start   = 1'b0;
		mul_ctl.msb_neg = 1'b0;
		mul_ctl.nbits   = MUL_CW'(16);
		mul_a           = MUL_AW'(lut_cos);
		mul_b           = MUL_BW'(depth_q);
		case (state_q)
			ST_M1: begin
				mul_ctl.start = 1'b1;
			end
			ST_M2: begin
				mul_ctl.start = 1'b1;
				mul_ctl.nbits = MUL_CW'(INV_W);
				mul_a         = arg_q;
				mul_b         = INV_TWO_PI_Q32;
			end
			ST_M3: begin
				mul_ctl.start   = 1'b1;
				mul_ctl.msb_neg = 1'b1;
				mul_ctl.nbits   = MUL_CW'(SAMPLE_BITS);
				mul_b           = MUL_BW'(x_q);
			end
			default: ;
		endcase
	end

	lpm_sermul u_sermul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.mcand  (mul_a),
		.mplier (mul_b),
		.sts    (mul_sts),
		.prod   (mul_p)
	);

	// argument in Q.23 radians: x scaled up plus depth * lfo
	logic signed [ARG_W-1:0] arg_next;
	assign arg_next = ARG_W'($signed(mul_p[32:0])) + (ARG_W'($signed(x_q)) <<< XSH);

	// x * cos, rounded half up, floor shift, saturated
	logic signed [P3_W-1:0]  p3;
	logic signed [SUM_W-1:0] psum;
	logic signed [YW-1:0]    yw;
	logic [SAMPLE_BITS-1:0]  y_sat;

	always_comb begin
		p3   = $signed(mul_p[P3_W-1:0]);
		psum = SUM_W'(p3) + SUM_W'(16384);
		yw   = psum[SUM_W-1:15];
		if (yw > YMAX) begin
			y_sat = YMAX[SAMPLE_BITS-1:0];
		end else if (yw < YMIN) begin
			y_sat = YMIN[SAMPLE_BITS-1:0];
		end else begin
			y_sat = yw[SAMPLE_BITS-1:0];
		end
	end

	// ---------------- sequencer ----------------
	logic out_load;

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						phase_q <= phase_q + PHASE_BITS'(inc_q);
						state_q <= ST_LFO;
					end
				end
				ST_LFO:  state_q <= ST_M1;
				ST_M1:   state_q <= ST_W1;
				ST_W1: begin
					if (mul_sts.done) begin
						state_q <= ST_M2;
					end
				end
				ST_M2:   state_q <= ST_W2;
				ST_W2: begin
					if (mul_sts.done) begin
						state_q <= ST_LUT2;
					end
				end
				ST_LUT2: state_q <= ST_M3;
				ST_M3:   state_q <= ST_W3;
				ST_W3: begin
					if (mul_sts.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// wait for the output register to free up
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			x_q <= sample_in;
		end
		if (state_q == ST_W1 && mul_sts.done) begin
			arg_q <= arg_next;
		end
		if (out_load) begin
			sample_out_q <= y_sat;
		end
	end

	// ---------------- assertions ----------------
	a_accept_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !mul_sts.busy)
		else $error("item accepted while multiplier busy");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_sts.done |-> (state_q == ST_W1 || state_q == ST_W2 || state_q == ST_W3))
		else $error("multiplier finished outside a wait state");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result raised without finishing an item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && out_stall) |=> state_q == ST_OUT)
		else $error("pending result overwritten");

endmodule

>>> sim/tb_lfo_phase_modulation_effect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lfo_phase_modulation_effect
// Self-checking bench for the LFO phase-modulation effect. Items go in with
// bursty valid and come out under a changing stall pattern. A bit-true
// predictor tracks the oscillator phase and the registers, and each result is
// compared in order. Registers are programmed over APB between phases.
// ----------------------------------------------------------------------------
module tb_lfo_phase_modulation_effect;
	import lpm_pkg::*;

	localparam int SW         = 16;
	localparam int QUARTER    = 256;
	localparam int LIMIT      = 2000000;
	localparam int LATENCY    = 80;
	localparam int MAX_REPORT = 50;
	localparam longint unsigned HALF_PI_Q30_C = 64'd1686629713;
	localparam longint unsigned INV_2PI_Q32   = 64'd683565276;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [SW-1:0]     sample_in = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [SW-1:0]     sample_out;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	lfo_phase_modulation_effect dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in),
		.out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	int            cos_quarter [QUARTER+1];
	logic [31:0]   lfo_phase;
	logic [31:0]   step_q;
	logic [15:0]   depth_q;
	logic [SW-1:0] expected_samples [$];

	int            errors = 0;
	int            cycle_count = 0;
	int            burst_left = 0;
	logic [SW-1:0] want_sample;

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		if (errors < MAX_REPORT)
			$display("mismatch @%0t: %s want %h got %h", $realtime, what, want, got);
		errors++;
	endtask

	function automatic void build_cos_quarter();
		longint unsigned ang, ang2, term, q;
		longint          sum;
		for (int k = 0; k <= QUARTER; k++) begin
			ang  = (64'(k) * HALF_PI_Q30_C) >> 8;
			ang2 = (ang * ang) >> 30;
			term = 64'd1 << 30;
			sum  = 64'sd1 << 30;
			for (int n = 1; n <= 7; n++) begin
				term = ((term * ang2) >> 30) / 64'((2 * n - 1) * (2 * n));
				if (n % 2)
					sum -= longint'(term);
				else
					sum += longint'(term);
			end
			if (sum < 0)
				sum = 0;
			q = ($unsigned(sum) + 64'd16384) >> 15;
			if (q > 64'd32767)
				q = 64'd32767;
			cos_quarter[k] = int'(q);
		end
	endfunction

	// quadrant from the top two bits, mirror/negate into the quarter table
	function automatic longint cos_at(logic [9:0] idx);
		int r;
		r = int'(idx[7:0]);
		case (idx[9:8])
			2'd0: return cos_quarter[r];
			2'd1: return -cos_quarter[QUARTER - r];
			2'd2: return -cos_quarter[r];
			default: return cos_quarter[QUARTER - r];
		endcase
	endfunction

	// advances the oscillator, then returns the expected output sample
	function automatic logic [SW-1:0] predict_sample_out(logic [SW-1:0] s);
		longint          x, lfo, depth, arg, p, y;
		longint unsigned turns;
		lfo_phase = lfo_phase + step_q;
		x     = longint'($signed(s));
		depth = longint'(depth_q);
		lfo   = cos_at(lfo_phase[31:22]);
		arg   = x * 256 + depth * lfo;
		turns = $unsigned(arg) * INV_2PI_Q32;
		p     = x * cos_at(turns[54:45]);
		y     = (p + 16384) >>> 15;
		if (y > 32767)
			y = 32767;
		if (y < -32768)
			y = -32768;
		return y[SW-1:0];
	endfunction

	task automatic apb_access(input logic wr, input reg_idx_t r, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {r, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(reg_idx_t r);
		logic [31:0] got, want;
		want = (r == REG_PHASE_INC) ? step_q : {16'h0, depth_q};
		apb_access(1'b0, r, 32'h0, got);
		if (got !== want)
			report_mismatch(r.name(), want, got);
	endtask

	task automatic program_reg(reg_idx_t r, logic [31:0] v);
		logic [31:0] unused;
		apb_access(1'b1, r, v, unused);
		if (r == REG_PHASE_INC)
			step_q = v;
		else
			depth_q = v[15:0];
		check_reg(r);
	endtask

	task automatic program_both(logic [31:0] step, logic [15:0] depth);
		program_reg(REG_PHASE_INC, step);
		program_reg(REG_MOD_DEPTH, {16'h0, depth});
	endtask

	// stop sending, wait out every pending result and the pipeline tail
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic send_sample(logic [SW-1:0] s);
		in_valid  <= 1'b1;
		sample_in <= s;
		do @(posedge clk); while (in_stall !== 1'b0);
		expected_samples.push_back(predict_sample_out(s));
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 150 : 20))
				@(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120)
				: $urandom_range(1, 8);
		end
	endtask

	function automatic logic [SW-1:0] random_sample();
		logic [SW-1:0] s;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: s = 16'h7fff;
					1: s = 16'h8000;
					2: s = 16'h0000;
					3: s = 16'hffff;
					default: s = 16'h0001;
				endcase
			end
			1: begin
				s = SW'($urandom_range(0, 255));
				if ($urandom_range(0, 1))
					s = -s;
			end
			default: s = SW'($urandom);
		endcase
		return s;
	endfunction

	// reset values read back, then a few items at the default depth
	task automatic test_reset_defaults();
		check_reg(REG_PHASE_INC);
		check_reg(REG_MOD_DEPTH);
		send_sample(16'h4000);
		send_sample(16'hc000);
		send_sample(16'h7fff);
		wait_drained();
	endtask

	task automatic test_directed_extremes();
		logic [SW-1:0] edge_vals [9] = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff,
			16'h8000, 16'h4000, 16'hc000, 16'h5555, 16'haaaa};
		program_both(32'h0, 16'h0);
		foreach (edge_vals[i])
			send_sample(edge_vals[i]);
		wait_drained();
		// quarter-turn steps land the oscillator on each quadrant boundary
		program_both(32'h4000_0000, 16'hffff);
		send_sample(16'h7fff);
		send_sample(16'h8000);
		send_sample(16'h3039);
		send_sample(16'h0000);
		wait_drained();
		program_reg(REG_PHASE_INC, 32'hffff_ffff);
		send_sample(16'h8000);
		send_sample(16'h7fff);
		wait_drained();
		program_both(32'h8000_0000, 16'h0001);
		send_sample(16'h1234);
		send_sample(16'hedcc);
		wait_drained();
	endtask

	task automatic test_random_phases();
		logic [31:0] step;
		logic [15:0] depth;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin step = 32'h0;               depth = 16'h0;      end
				1: begin step = 32'hffff_ffff;       depth = 16'hffff;   end
				2: begin step = 32'h0040_0000;       depth = 16'd2560;   end
				3: begin step = $urandom;            depth = 16'($urandom); end
				4: begin step = $urandom_range(1, 1 << 20); depth = 16'($urandom); end
				5: begin step = 32'h0040_0000 * $urandom_range(1, 1023); depth = 16'hffff; end
				6: begin step = $urandom;            depth = 16'h0;      end
				default: begin step = $urandom;      depth = 16'($urandom); end
			endcase
			program_both(step, depth);
			for (int n = 0; n < 240; n++) begin
				send_sample(random_sample());
				if (ph == 3 && n == 120)
					wait_drained();
			end
			wait_drained();
		end
	endtask

	// receiver: picks a new random stall mode each time its random span runs out
	int stall_mode = 0;
	int stall_span = 0;
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_span = $urandom_range(64, 600);
		end
		stall_span--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (stall_span % 40) < 25;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_samples.size() == 0) begin
				report_mismatch("sample_out with nothing pending", 32'h0, {16'h0, sample_out});
			end else begin
				want_sample = expected_samples.pop_front();
				if (sample_out !== want_sample)
					report_mismatch("sample_out", {16'h0, want_sample}, {16'h0, sample_out});
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		build_cos_quarter();
		lfo_phase = '0;
		step_q    = '0;
		depth_q   = DEPTH_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_extremes();
		test_random_phases();
		wait_drained();
		if (expected_samples.size() != 0)
			report_mismatch("items left without a result", 32'h0, expected_samples.size());
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
